// ===== hdl/sqps_pkg.sv =====
// shared types and constants for the serial ram slave core
// no dependencies; the files that use it refer to it by scoped names
`default_nettype none

package sqps_pkg;

    localparam int ADDR_BITS_DEFAULT   = 17;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // address increments wrap inside a 1 KiB block
    localparam int WRAP_BITS = 10;
    localparam int BUF_BITS  = 24;

    localparam logic [7:0] CMD_READ       = 8'h03;
    localparam logic [7:0] CMD_FAST_READ  = 8'h0b;
    localparam logic [7:0] CMD_QUAD_READ  = 8'heb;
    localparam logic [7:0] CMD_WRITE      = 8'h02;
    localparam logic [7:0] CMD_QUAD_WRITE = 8'h38;
    localparam logic [7:0] CMD_ENTER_QUAD = 8'h35;
    localparam logic [7:0] CMD_EXIT_QUAD  = 8'hf5;
    localparam logic [7:0] CMD_RESET_EN   = 8'h66;
    localparam logic [7:0] CMD_RESET      = 8'h99;

    // bit counts loaded for the shift phases
    localparam logic [4:0] BITS_BYTE    = 5'd8;
    localparam logic [4:0] BITS_ADDRESS = 5'd24;
    localparam logic [4:0] WAIT_NONE    = 5'd0;
    localparam logic [4:0] WAIT_SINGLE  = 5'd8;
    localparam logic [4:0] WAIT_QUAD    = 5'd16;
    localparam logic [4:0] WAIT_QUAD_IO = 5'd24;

    localparam logic [3:0] OUT_IDLE   = 4'hf;
    localparam logic [3:0] OUT_SO_LOW = 4'hd;
    localparam logic [3:0] DRV_NONE   = 4'h0;
    localparam logic [3:0] DRV_SINGLE = 4'h2;
    localparam logic [3:0] DRV_QUAD   = 4'hf;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_ADDR,
        PH_WAIT,
        PH_READ,
        PH_WRITE
    } phase_t;

    typedef struct packed {
        logic [3:0] sio_out;
        logic [3:0] sio_drive;
    } drive_t;

endpackage

`default_nettype wire

// ===== hdl/sqps_if.sv =====
// handshake channels of the serial ram slave core: pin samples, pin drive, config
// no dependencies
`default_nettype none

interface sqps_pin_if;
    logic       valid;
    logic       ready;
    logic       ce_n;
    logic       sclk;
    logic [3:0] sio_in;

    modport source (output valid, output ce_n, output sclk, output sio_in, input ready);
    modport sink (input valid, input ce_n, input sclk, input sio_in, output ready);
endinterface

interface sqps_drive_if;
    logic       valid;
    logic       ready;
    logic [3:0] sio_out;
    logic [3:0] sio_drive;

    modport source (output valid, output sio_out, output sio_drive, input ready);
    modport sink (input valid, input sio_out, input sio_drive, output ready);
endinterface

interface sqps_cfg_if;
    logic valid;
    logic ready;
    logic psram_mode;

    modport source (output valid, output psram_mode, input ready);
    modport sink (input valid, input psram_mode, output ready);
endinterface

`default_nettype wire

// ===== hdl/sqps_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module sqps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/sqps_front.sv =====
// pin sampler and protocol engine: edge detection, command decode, address and data shifting
// depends on sqps_pkg and sqps_if; drives the memory ports and pushes drive words to the queue
`default_nettype none

module sqps_front #(
    parameter int ADDR_BITS = sqps_pkg::ADDR_BITS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    sqps_pin_if.sink              pins,
    sqps_cfg_if.sink              cfg,
    input  logic                  q_full,
    output logic                  push,
    output sqps_pkg::drive_t      push_data,
    output logic                  mem_we,
    output logic [ADDR_BITS-1:0]  mem_waddr,
    output logic [7:0]            mem_wdata,
    output logic [ADDR_BITS-1:0]  mem_raddr,
    input  logic [7:0]            mem_rdata
);

    localparam int BB = sqps_pkg::BUF_BITS;
    localparam logic [ADDR_BITS-1:0] WRAP_MASK =
        ADDR_BITS'((1 << sqps_pkg::WRAP_BITS) - 1);

    sqps_pkg::phase_t     phase_reg, phase_next;
    logic [BB-1:0]        shift_reg, shift_next;
    logic [4:0]           bits_reg, bits_next;
    logic                 after_read_reg, after_read_next;
    logic                 quad_cmd_reg, quad_cmd_next;
    logic                 quad_data_reg, quad_data_next;
    logic [4:0]           wait_reg, wait_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic                 last_ce_n_reg, last_ce_n_next;
    logic                 last_sclk_reg, last_sclk_next;
    logic                 armed_reg, armed_next;
    logic                 mode_reg, mode_next;
    logic                 pending_reg, pending_next;
    logic                 clear_reg, clear_next;
    logic [ADDR_BITS-1:0] clear_addr_reg, clear_addr_next;

    logic                 fire;
    logic                 start;
    sqps_pkg::phase_t     phase_mid;
    logic [BB-1:0]        shift_cur;
    logic [BB-1:0]        sb_mid;
    logic                 qd_mid;
    logic [4:0]           bl_mid;
    logic [4:0]           lane;
    logic [4:0]           bl_dec;
    logic                 bl_done;
    logic [BB-1:0]        sb_in;
    logic                 rising;
    logic                 falling;
    logic [ADDR_BITS-1:0] addr_inc;
    logic [ADDR_BITS-1:0] addr_adv;
    logic [ADDR_BITS-1:0] addr_from_sb;
    logic                 rd_issue;

    assign pins.ready = !clear_reg && !q_full;
    assign cfg.ready  = 1'b1;
    assign fire       = pins.valid && pins.ready;

    // a byte fetched last cycle lands in the shift buffer now
    assign shift_cur = pending_reg ? {{(BB-8){1'b0}}, mem_rdata} : shift_reg;

    assign start     = !pins.ce_n && last_ce_n_reg;
    assign phase_mid = pins.ce_n ? sqps_pkg::PH_IDLE :
                       (start ? sqps_pkg::PH_CMD : phase_reg);
    assign sb_mid    = start ? '0 : shift_cur;
    assign qd_mid    = start ? quad_cmd_reg : quad_data_reg;
    assign bl_mid    = start ? sqps_pkg::BITS_BYTE : bits_reg;
    assign lane      = qd_mid ? 5'd4 : 5'd1;
    assign bl_dec    = (bl_mid > lane) ? (bl_mid - lane) : 5'd0;
    assign bl_done   = (bl_dec == 5'd0);
    assign sb_in     = qd_mid ? {sb_mid[BB-5:0], pins.sio_in} :
                                {sb_mid[BB-2:0], pins.sio_in[0]};
    assign rising    = pins.sclk && !last_sclk_reg;
    assign falling   = !pins.sclk && last_sclk_reg;

    assign addr_inc     = addr_reg + ADDR_BITS'(1);
    assign addr_adv     = (addr_reg & ~WRAP_MASK) | (addr_inc & WRAP_MASK);
    assign addr_from_sb = sb_in[ADDR_BITS-1:0];

    // next state
    always_comb
    begin
        logic       plain;
        logic       do_xfer;
        logic       x_quad;
        logic [4:0] x_wait;
        logic       x_read;
        logic [7:0] cmd;

        plain   = 1'b0;
        do_xfer = 1'b0;
        x_quad  = 1'b0;
        x_wait  = sqps_pkg::WAIT_NONE;
        x_read  = 1'b0;
        cmd     = sb_in[7:0];

        phase_next      = phase_reg;
        shift_next      = shift_cur;
        bits_next       = bits_reg;
        after_read_next = after_read_reg;
        quad_cmd_next   = quad_cmd_reg;
        quad_data_next  = quad_data_reg;
        wait_next       = wait_reg;
        addr_next       = addr_reg;
        last_ce_n_next  = last_ce_n_reg;
        last_sclk_next  = last_sclk_reg;
        armed_next      = armed_reg;
        mode_next       = mode_reg;
        pending_next    = rd_issue;
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;

        if (clear_reg)
        begin
            clear_addr_next = clear_addr_reg + ADDR_BITS'(1);
            if (&clear_addr_reg)
            begin
                clear_next = 1'b0;
            end
        end

        if (cfg.valid)
        begin
            mode_next = cfg.psram_mode;
        end

        if (fire)
        begin
            last_ce_n_next = pins.ce_n;
            last_sclk_next = pins.sclk;
            phase_next     = phase_mid;
            shift_next     = sb_mid;
            quad_data_next = qd_mid;
            bits_next      = bl_mid;

            case (phase_mid)
                sqps_pkg::PH_CMD, sqps_pkg::PH_ADDR, sqps_pkg::PH_WRITE:
                begin
                    if (rising)
                    begin
                        shift_next = sb_in;
                        bits_next  = bl_dec;
                        if (bl_done)
                        begin
                            case (phase_mid)
                                sqps_pkg::PH_CMD:
                                begin
                                    phase_next = sqps_pkg::PH_IDLE;
                                    if (mode_reg)
                                    begin
                                        armed_next = 1'b0;
                                        case (cmd)
                                            sqps_pkg::CMD_READ:
                                            begin
                                                if (quad_cmd_reg)
                                                begin
                                                    do_xfer = 1'b1;
                                                    x_quad  = 1'b1;
                                                    x_wait  = sqps_pkg::WAIT_QUAD;
                                                    x_read  = 1'b1;
                                                end
                                                else
                                                begin
                                                    plain = 1'b1;
                                                end
                                            end
                                            sqps_pkg::CMD_FAST_READ:
                                            begin
                                                do_xfer = 1'b1;
                                                x_quad  = quad_cmd_reg;
                                                x_wait  = quad_cmd_reg ? sqps_pkg::WAIT_QUAD :
                                                                         sqps_pkg::WAIT_SINGLE;
                                                x_read  = 1'b1;
                                            end
                                            sqps_pkg::CMD_QUAD_READ:
                                            begin
                                                do_xfer = 1'b1;
                                                x_quad  = 1'b1;
                                                x_wait  = sqps_pkg::WAIT_QUAD_IO;
                                                x_read  = 1'b1;
                                            end
                                            sqps_pkg::CMD_QUAD_WRITE:
                                            begin
                                                do_xfer = 1'b1;
                                                x_quad  = 1'b1;
                                            end
                                            sqps_pkg::CMD_ENTER_QUAD:
                                            begin
                                                if (!quad_cmd_reg)
                                                begin
                                                    quad_cmd_next = 1'b1;
                                                end
                                            end
                                            sqps_pkg::CMD_EXIT_QUAD:
                                            begin
                                                if (quad_cmd_reg)
                                                begin
                                                    quad_cmd_next = 1'b0;
                                                end
                                            end
                                            sqps_pkg::CMD_RESET_EN:
                                            begin
                                                armed_next = 1'b1;
                                            end
                                            sqps_pkg::CMD_RESET:
                                            begin
                                                if (armed_reg)
                                                begin
                                                    quad_cmd_next = 1'b0;
                                                end
                                            end
                                            default:
                                            begin
                                                plain = 1'b1;
                                            end
                                        endcase
                                    end
                                    else
                                    begin
                                        plain = 1'b1;
                                    end

                                    if (plain)
                                    begin
                                        if (cmd == sqps_pkg::CMD_READ)
                                        begin
                                            do_xfer = 1'b1;
                                            x_quad  = quad_cmd_reg;
                                            x_read  = 1'b1;
                                        end
                                        else if (cmd == sqps_pkg::CMD_WRITE)
                                        begin
                                            do_xfer = 1'b1;
                                            x_quad  = quad_cmd_reg;
                                        end
                                    end

                                    if (do_xfer)
                                    begin
                                        shift_next      = '0;
                                        quad_data_next  = x_quad;
                                        bits_next       = sqps_pkg::BITS_ADDRESS;
                                        wait_next       = x_wait;
                                        phase_next      = sqps_pkg::PH_ADDR;
                                        after_read_next = x_read;
                                    end
                                end
                                sqps_pkg::PH_ADDR:
                                begin
                                    addr_next = addr_from_sb;
                                    if (wait_reg != 5'd0)
                                    begin
                                        phase_next = sqps_pkg::PH_WAIT;
                                        bits_next  = wait_reg;
                                    end
                                    else
                                    begin
                                        shift_next = '0;
                                        bits_next  = sqps_pkg::BITS_BYTE;
                                        phase_next = after_read_reg ? sqps_pkg::PH_READ :
                                                                      sqps_pkg::PH_WRITE;
                                    end
                                end
                                default:
                                begin
                                    shift_next = '0;
                                    addr_next  = addr_adv;
                                    bits_next  = sqps_pkg::BITS_BYTE;
                                end
                            endcase
                        end
                    end
                end
                sqps_pkg::PH_WAIT:
                begin
                    if (rising)
                    begin
                        bits_next = bl_dec;
                        if (bl_done)
                        begin
                            shift_next = '0;
                            bits_next  = sqps_pkg::BITS_BYTE;
                            phase_next = after_read_reg ? sqps_pkg::PH_READ :
                                                          sqps_pkg::PH_WRITE;
                        end
                    end
                end
                sqps_pkg::PH_READ:
                begin
                    if (falling)
                    begin
                        shift_next = qd_mid ? {{(BB-8){1'b0}}, sb_mid[3:0], 4'b0} :
                                              {{(BB-8){1'b0}}, sb_mid[6:0], 1'b0};
                        bits_next  = bl_dec;
                        if (bl_done)
                        begin
                            addr_next = addr_adv;
                            bits_next = sqps_pkg::BITS_BYTE;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // drive words and memory ports
    always_comb
    begin
        push      = 1'b0;
        push_data = sqps_pkg::drive_t'{sio_out: sqps_pkg::OUT_IDLE,
                                       sio_drive: sqps_pkg::DRV_NONE};
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = sb_in[7:0];
        rd_issue  = 1'b0;

        case (phase_mid)
            sqps_pkg::PH_ADDR: mem_raddr = addr_from_sb;
            sqps_pkg::PH_WAIT: mem_raddr = addr_reg;
            default:           mem_raddr = addr_adv;
        endcase

        if (fire)
        begin
            if (pins.ce_n)
            begin
                push = 1'b1;
            end
            else if (phase_mid == sqps_pkg::PH_READ && falling)
            begin
                push = 1'b1;
                if (qd_mid)
                begin
                    push_data = sqps_pkg::drive_t'{sio_out: sb_mid[7:4],
                                                   sio_drive: sqps_pkg::DRV_QUAD};
                end
                else
                begin
                    push_data = sqps_pkg::drive_t'{
                        sio_out: sb_mid[7] ? sqps_pkg::OUT_IDLE : sqps_pkg::OUT_SO_LOW,
                        sio_drive: sqps_pkg::DRV_SINGLE};
                end
                rd_issue = bl_done;
            end

            if (phase_mid == sqps_pkg::PH_WRITE && rising && bl_done)
            begin
                mem_we = 1'b1;
            end
            if (phase_mid == sqps_pkg::PH_ADDR && rising && bl_done &&
                wait_reg == 5'd0 && after_read_reg)
            begin
                rd_issue = 1'b1;
            end
            if (phase_mid == sqps_pkg::PH_WAIT && rising && bl_done && after_read_reg)
            begin
                rd_issue = 1'b1;
            end
        end

        // zero fill after reset owns the write port
        if (clear_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_addr_reg;
            mem_wdata = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= sqps_pkg::PH_IDLE;
            shift_reg      <= '0;
            bits_reg       <= 5'd0;
            after_read_reg <= 1'b0;
            quad_cmd_reg   <= 1'b0;
            quad_data_reg  <= 1'b0;
            wait_reg       <= 5'd0;
            addr_reg       <= '0;
            last_ce_n_reg  <= 1'b1;
            last_sclk_reg  <= 1'b0;
            armed_reg      <= 1'b0;
            mode_reg       <= 1'b1;
            pending_reg    <= 1'b0;
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            bits_reg       <= bits_next;
            after_read_reg <= after_read_next;
            quad_cmd_reg   <= quad_cmd_next;
            quad_data_reg  <= quad_data_next;
            wait_reg       <= wait_next;
            addr_reg       <= addr_next;
            last_ce_n_reg  <= last_ce_n_next;
            last_sclk_reg  <= last_sclk_next;
            armed_reg      <= armed_next;
            mode_reg       <= mode_next;
            pending_reg    <= pending_next;
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sqps_queue.sv =====
// short queue of drive words between the protocol engine and the output stage
// depends on sqps_pkg
`default_nettype none

module sqps_queue #(
    parameter int DEPTH = sqps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sqps_pkg::drive_t push_data,
    output logic             full,
    input  logic             pop,
    output sqps_pkg::drive_t head,
    output logic             not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    sqps_pkg::drive_t slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/sqps_back.sv =====
// output stage: drops drive words equal to the last one sent, holds the output register
// depends on sqps_pkg and sqps_if
`default_nettype none

module sqps_back (
    input  logic             clk,
    input  logic             rst_n,
    input  sqps_pkg::drive_t head,
    input  logic             head_valid,
    output logic             pop,
    sqps_drive_if.source     drive
);

    sqps_pkg::drive_t prev_reg, prev_next;
    sqps_pkg::drive_t data_reg, data_next;
    logic             valid_reg, valid_next;

    assign pop = head_valid && (!valid_reg || drive.ready);

    always_comb
    begin
        prev_next  = prev_reg;
        data_next  = data_reg;
        valid_next = valid_reg;
        if (drive.ready)
        begin
            valid_next = 1'b0;
        end
        if (pop && head != prev_reg)
        begin
            prev_next  = head;
            data_next  = head;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= sqps_pkg::drive_t'{sio_out: sqps_pkg::OUT_IDLE,
                                            sio_drive: sqps_pkg::DRV_NONE};
            valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg  <= prev_next;
            valid_reg <= valid_next;
        end
    end

    assign drive.valid     = valid_reg;
    assign drive.sio_out   = data_reg.sio_out;
    assign drive.sio_drive = data_reg.sio_drive;

endmodule

`default_nettype wire

// ===== hdl/spi_qpi_psram_slave_core.sv =====
// top level of the serial ram slave core: protocol engine, ram, drive queue, output stage
// depends on sqps_pkg, sqps_if, sqps_ram, sqps_front, sqps_queue and sqps_back
`default_nettype none

// One pin sample (chip enable, serial clock, four data pins) is taken per clock whenever
// the drive queue has room, so samples may follow each other every cycle. A sample that
// changes what the device drives yields a drive word on the drive channel after it
// passes the drive queue and the output register; samples that leave the drive as it was
// yield nothing. Read data comes from the single ram read port, whose registered output
// is folded into the shift buffer on the cycle after the fetch, ahead of the next falling
// serial clock. After reset a clearing pass writes zero to all 2^ADDR_BITS bytes, one per
// clock, while pins.ready stays low; config writes are taken at any time and the mode
// applies to commands decoded after the write is taken.
module spi_qpi_psram_slave_core #(
    parameter int ADDR_BITS   = sqps_pkg::ADDR_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = sqps_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    sqps_pin_if.sink     pins,
    sqps_cfg_if.sink     cfg,
    sqps_drive_if.source drive
);

    logic                 q_full;
    logic                 push;
    sqps_pkg::drive_t     push_data;
    logic                 pop;
    sqps_pkg::drive_t     head;
    logic                 head_valid;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr;
    logic [7:0]           mem_wdata;
    logic [ADDR_BITS-1:0] mem_raddr;
    logic [7:0]           mem_rdata;

    sqps_front #(
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pins      (pins),
        .cfg       (cfg),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sqps_ram #(
        .WIDTH (8),
        .DEPTH (1 << ADDR_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sqps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .not_empty (head_valid)
    );

    sqps_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .drive      (drive)
    );

endmodule

`default_nettype wire

// ===== hdl/sqps_checker.sv =====
// port level checks of the serial ram slave core, bound to the top level
// depends on sqps_pkg and spi_qpi_psram_slave_core
`default_nettype none

module sqps_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] sio_out,
    input logic [3:0] sio_drive
);

    logic [7:0] last_reg;

    // last drive word taken by the sink
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= {sqps_pkg::OUT_IDLE, sqps_pkg::DRV_NONE};
        end
        else if (out_valid && out_ready)
        begin
            last_reg <= {sio_out, sio_drive};
        end
    end

    // memory clearing keeps samples out right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !in_ready)
        else $error("pin samples taken before memory clearing finished");

    a_word_changes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> {sio_out, sio_drive} != last_reg)
        else $error("drive word repeats the previous one");

    a_drive_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sio_drive == sqps_pkg::DRV_NONE || sio_drive == sqps_pkg::DRV_SINGLE ||
                      sio_drive == sqps_pkg::DRV_QUAD)
        else $error("illegal drive mask");

    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sio_drive != sqps_pkg::DRV_QUAD |->
            sio_out == sqps_pkg::OUT_IDLE || sio_out == sqps_pkg::OUT_SO_LOW)
        else $error("undriven pins not reading high");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sio_out) && $stable(sio_drive))
        else $error("stalled drive word changed");

endmodule

bind spi_qpi_psram_slave_core sqps_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pins.ready),
    .out_valid (drive.valid),
    .out_ready (drive.ready),
    .sio_out   (drive.sio_out),
    .sio_drive (drive.sio_drive)
);

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for spi_qpi_psram_slave_core: drives pin samples, predicts the pin
// drive words and compares them on the drive channel; needs sqps_pkg, sqps_if and the core rtl
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W        = sqps_pkg::ADDR_BITS_DEFAULT;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_SAMPLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE        = 8;
    localparam int MAX_REPORTS   = 10;

    // command code the device does not know
    localparam logic [7:0] CMD_NONE_HIGH = 8'hff;

    class pin_drive_scoreboard;
        bit [7:0]    ram [1 << ADDR_W];
        bit          psram_mode;
        bit [23:0]   shift_buf;
        int unsigned bits_due;
        sqps_pkg::phase_t bus;
        bit          read_access;
        bit          quad_cmd;
        bit          quad_dat;
        bit          armed;
        int unsigned wait_count;
        bit [ADDR_W-1:0] cur_addr;
        bit          ce_seen;
        bit          sclk_seen;
        sqps_pkg::drive_t last_drive;
        sqps_pkg::drive_t words_due[$];
        int          mismatches;
        int          samples;
        int          words_made;

        function new();
            psram_mode = 1'b1;
            ce_seen = 1'b1;
            bus = sqps_pkg::PH_IDLE;
            last_drive = '{sqps_pkg::OUT_IDLE, sqps_pkg::DRV_NONE};
        endfunction

        function int unsigned consume(int unsigned w);
            bits_due = (bits_due > w) ? bits_due - w : 0;
            return bits_due;
        endfunction

        function void start_access(bit quad, int unsigned cycles, bit rd);
            shift_buf = '0;
            quad_dat = quad;
            bits_due = sqps_pkg::BITS_ADDRESS;
            wait_count = cycles * (quad ? 4 : 1);
            bus = sqps_pkg::PH_ADDR;
            read_access = rd;
        endfunction

        // increments wrap inside the 1 KiB block
        function void step_address();
            cur_addr[sqps_pkg::WRAP_BITS-1:0] = cur_addr[sqps_pkg::WRAP_BITS-1:0] + 1'b1;
            bits_due = sqps_pkg::BITS_BYTE;
        endfunction

        function void load_data_phase();
            shift_buf = read_access ? 24'(ram[cur_addr]) : 24'h0;
            bits_due = sqps_pkg::BITS_BYTE;
            bus = read_access ? sqps_pkg::PH_READ : sqps_pkg::PH_WRITE;
        endfunction

        function void decode_command(bit [7:0] code);
            bit qc;
            bit was_armed;
            qc = quad_cmd;
            if (psram_mode)
            begin
                was_armed = armed;
                armed = 1'b0;
                case (code)
                    sqps_pkg::CMD_READ:
                        if (qc)
                        begin
                            start_access(1'b1, 4, 1'b1);
                            return;
                        end
                    sqps_pkg::CMD_FAST_READ:
                    begin
                        start_access(qc, qc ? 4 : 8, 1'b1);
                        return;
                    end
                    sqps_pkg::CMD_QUAD_READ:
                    begin
                        start_access(1'b1, 6, 1'b1);
                        return;
                    end
                    sqps_pkg::CMD_QUAD_WRITE:
                    begin
                        start_access(1'b1, 0, 1'b0);
                        return;
                    end
                    sqps_pkg::CMD_ENTER_QUAD:
                        if (!qc)
                        begin
                            quad_cmd = 1'b1;
                            return;
                        end
                    sqps_pkg::CMD_EXIT_QUAD:
                        if (qc)
                        begin
                            quad_cmd = 1'b0;
                            return;
                        end
                    sqps_pkg::CMD_RESET_EN:
                    begin
                        armed = 1'b1;
                        return;
                    end
                    sqps_pkg::CMD_RESET:
                    begin
                        if (was_armed)
                            quad_cmd = 1'b0;
                        return;
                    end
                    default: ;
                endcase
            end
            if (code == sqps_pkg::CMD_READ)
                start_access(qc, 0, 1'b1);
            else if (code == sqps_pkg::CMD_WRITE)
                start_access(qc, 0, 1'b0);
        endfunction

        function void take_sample(bit ce, bit sck, bit [3:0] sio);
            sqps_pkg::drive_t nxt;
            bit          touched;
            int unsigned w;
            bit [3:0]    lanes;
            bit          rise_e;
            bit          fall_e;
            nxt = last_drive;
            touched = 1'b0;
            samples++;
            // chip enable is looked at before the clock edge
            if (ce)
            begin
                touched = 1'b1;
                nxt = '{sqps_pkg::OUT_IDLE, sqps_pkg::DRV_NONE};
                bus = sqps_pkg::PH_IDLE;
            end
            else if (ce_seen)
            begin
                shift_buf = '0;
                quad_dat = quad_cmd;
                bits_due = sqps_pkg::BITS_BYTE;
                bus = sqps_pkg::PH_CMD;
            end
            ce_seen = ce;
            w = quad_dat ? 4 : 1;
            lanes = quad_dat ? sio : {3'b000, sio[0]};
            rise_e = sck && !sclk_seen;
            fall_e = !sck && sclk_seen;
            case (bus)
                sqps_pkg::PH_CMD, sqps_pkg::PH_ADDR, sqps_pkg::PH_WRITE:
                    if (rise_e)
                    begin
                        shift_buf = (shift_buf << w) | 24'(lanes);
                        if (consume(w) == 0)
                        begin
                            if (bus == sqps_pkg::PH_CMD)
                            begin
                                bus = sqps_pkg::PH_IDLE;
                                decode_command(shift_buf[7:0]);
                            end
                            else if (bus == sqps_pkg::PH_ADDR)
                            begin
                                cur_addr = shift_buf[ADDR_W-1:0];
                                if (wait_count != 0)
                                begin
                                    bus = sqps_pkg::PH_WAIT;
                                    bits_due = wait_count % 32;
                                end
                                else
                                    load_data_phase();
                            end
                            else
                            begin
                                ram[cur_addr] = shift_buf[7:0];
                                shift_buf = '0;
                                step_address();
                            end
                        end
                    end
                sqps_pkg::PH_WAIT:
                    if (rise_e && consume(w) == 0)
                        load_data_phase();
                sqps_pkg::PH_READ:
                    if (fall_e)
                    begin
                        touched = 1'b1;
                        if (quad_dat)
                            nxt = '{shift_buf[7:4], sqps_pkg::DRV_QUAD};
                        else
                            nxt = '{shift_buf[7] ? sqps_pkg::OUT_IDLE : sqps_pkg::OUT_SO_LOW,
                                    sqps_pkg::DRV_SINGLE};
                        shift_buf = (shift_buf << w) & 24'hff;
                        if (consume(w) == 0)
                        begin
                            step_address();
                            shift_buf = 24'(ram[cur_addr]);
                            bits_due = sqps_pkg::BITS_BYTE;
                        end
                    end
                default: ;
            endcase
            sclk_seen = sck;
            if (touched && nxt != last_drive)
            begin
                last_drive = nxt;
                words_due.push_back(nxt);
                words_made++;
            end
        endfunction

        function void check_drive(logic [3:0] sout, logic [3:0] sdrv);
            sqps_pkg::drive_t want;
            if (words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected drive word: sio_out=%h sio_drive=%h", sout, sdrv);
                return;
            end
            want = words_due.pop_front();
            if (sout !== want.sio_out || sdrv !== want.sio_drive)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("drive word mismatch: expected out=%h drive=%h, got out=%h drive=%h",
                             want.sio_out, want.sio_drive, sout, sdrv);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycle_count = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_req = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    bit   cur_sclk = 1'b0;
    pin_drive_scoreboard sb;

    sqps_pin_if   pins();
    sqps_cfg_if   cfg();
    sqps_drive_if drive();

    spi_qpi_psram_slave_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pins  (pins),
        .cfg   (cfg),
        .drive (drive)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // drive word receiver, with random stalls and the long hold-off
    initial
    begin
        drive.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (drive.valid && drive.ready)
                sb.check_drive(drive.sio_out, drive.sio_drive);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                drive.ready <= 1'b0;
            end
            else
                drive.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic bit [3:0] pin_noise();
        return 4'($urandom);
    endfunction

    task automatic put_sample(bit ce, bit sck, bit [3:0] sio);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            pins.valid <= 1'b0;
            @(posedge clk);
        end
        pins.valid  <= 1'b1;
        pins.ce_n   <= ce;
        pins.sclk   <= sck;
        pins.sio_in <= sio;
        do
            @(posedge clk);
        while (!pins.ready);
        sb.take_sample(ce, sck, sio);
        cur_sclk = sck;
    endtask

    // sometimes chip enable and the clock hold their levels for an extra sample
    task automatic maybe_repeat();
        if ($urandom_range(0, 5) == 0)
            put_sample(1'b0, cur_sclk, pin_noise());
    endtask

    task automatic rise(bit [3:0] sio);
        if (cur_sclk)
        begin
            put_sample(1'b0, 1'b0, pin_noise());
            maybe_repeat();
        end
        put_sample(1'b0, 1'b1, sio);
        maybe_repeat();
    endtask

    task automatic read_edges(int n);
        repeat (n)
        begin
            if (!cur_sclk)
                put_sample(1'b0, 1'b1, pin_noise());
            put_sample(1'b0, 1'b0, pin_noise());
            maybe_repeat();
        end
    endtask

    task automatic shift_word(bit [23:0] v, int nbits, bit quad);
        int       step;
        bit [3:0] lanes;
        step = quad ? 4 : 1;
        for (int i = nbits - step; i >= 0; i -= step)
        begin
            lanes = 4'(v >> i);
            if (!quad)
                lanes[3:1] = 3'($urandom);
            rise(lanes);
        end
    endtask

    task automatic write_bytes(int n);
        repeat (n)
            shift_word(24'($urandom), 8, sb.quad_dat);
    endtask

    // chip enable falls, then command, address and wait cycles as the device asks for them
    task automatic begin_access(bit [7:0] code, bit [23:0] addr, bit same_edge);
        put_sample(1'b1, 1'b0, pin_noise());
        if (!same_edge)
            put_sample(1'b0, 1'b0, pin_noise());
        shift_word(24'(code), 8, sb.quad_cmd);
        if (sb.bus == sqps_pkg::PH_ADDR)
        begin
            shift_word(addr, 24, sb.quad_dat);
            while (sb.bus == sqps_pkg::PH_WAIT)
                rise(pin_noise());
        end
    endtask

    task automatic end_access();
        put_sample(1'b1, 1'($urandom), pin_noise());
    endtask

    task automatic transfer(bit [7:0] code, bit [23:0] addr, int nbytes, bit same_edge);
        begin_access(code, addr, same_edge);
        if (sb.bus == sqps_pkg::PH_READ)
            read_edges(nbytes * (sb.quad_dat ? 2 : 8));
        else if (sb.bus == sqps_pkg::PH_WRITE)
            write_bytes(nbytes);
        else
            repeat (2) rise(pin_noise());
        end_access();
    endtask

    task automatic drain();
        pins.valid <= 1'b0;
        while (sb.words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_mode(bit m);
        drain();
        cfg.valid      <= 1'b1;
        cfg.psram_mode <= m;
        do
            @(posedge clk);
        while (!cfg.ready);
        sb.psram_mode = m;
        cfg.valid <= 1'b0;
    endtask

    function automatic bit [23:0] pick_address();
        bit [23:0] a;
        a = 24'($urandom);
        if ($urandom_range(0, 3) != 0)
            a[16:10] = 7'($urandom_range(0, 1));
        if ($urandom_range(0, 1) != 0)
            a[9:0] = 10'h3fc + 10'($urandom_range(0, 3));
        else
            a[9:0] = 10'($urandom_range(0, 15));
        return a;
    endfunction

    function automatic bit [7:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return sqps_pkg::CMD_WRITE;
        if (r < 35)
            return sqps_pkg::CMD_QUAD_WRITE;
        if (r < 55)
            return sqps_pkg::CMD_READ;
        if (r < 65)
            return sqps_pkg::CMD_FAST_READ;
        if (r < 75)
            return sqps_pkg::CMD_QUAD_READ;
        if (r < 80)
            return sqps_pkg::CMD_ENTER_QUAD;
        if (r < 85)
            return sqps_pkg::CMD_EXIT_QUAD;
        if (r < 90)
            return sqps_pkg::CMD_RESET_EN;
        if (r < 94)
            return sqps_pkg::CMD_RESET;
        return 8'($urandom);
    endfunction

    task automatic random_access();
        bit [7:0] code;
        int       n;
        code = pick_command();
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(2, 12))
                put_sample(1'($urandom_range(0, 3) == 0), 1'($urandom), pin_noise());
            end_access();
        end
        begin_access(code, pick_address(), $urandom_range(0, 7) == 0);
        if (sb.bus == sqps_pkg::PH_READ)
        begin
            n = $urandom_range(1, 4) * (sb.quad_dat ? 2 : 8);
            // now and then chip enable rises in the middle of a byte
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(1, n);
            read_edges(n);
        end
        else if (sb.bus == sqps_pkg::PH_WRITE)
        begin
            write_bytes($urandom_range(1, 4));
            if ($urandom_range(0, 7) == 0)
                rise(pin_noise());
        end
        else if ($urandom_range(0, 1) != 0)
            repeat (2) rise(pin_noise());
        end_access();
        if ($urandom_range(0, 39) == 0)
            drain();
    endtask

    task automatic random_phase(int idle, int stall, bit mode);
        int first;
        set_mode(mode);
        idle_pct = idle;
        stall_pct = stall;
        first = sb.samples;
        while (sb.samples - first < PHASE_SAMPLES)
            random_access();
    endtask

    initial
    begin
        sb = new();
        pins.valid = 1'b0;
        pins.ce_n = 1'b1;
        pins.sclk = 1'b0;
        pins.sio_in = 4'h0;
        cfg.valid = 1'b0;
        cfg.psram_mode = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(1'b1);
        transfer(sqps_pkg::CMD_WRITE, 24'hfe03ff, 2, 1'b0);
        // clock rises in the same sample as chip enable falls
        transfer(sqps_pkg::CMD_READ, 24'h0003ff, 2, 1'b1);

        // long read while the receiver holds off, so the input side backs up
        begin_access(sqps_pkg::CMD_QUAD_READ, 24'h01ffff, 1'b0);
        hold_req <= hold_req + 1;
        read_edges(24);
        end_access();

        transfer(CMD_NONE_HIGH, 24'h0, 1, 1'b0);

        transfer(sqps_pkg::CMD_ENTER_QUAD, 24'h0, 0, 1'b0);
        transfer(sqps_pkg::CMD_READ, 24'h0003fe, 2, 1'b0);
        transfer(sqps_pkg::CMD_WRITE, 24'h000010, 2, 1'b0);
        // reset without a preceding enable leaves quad commands on
        transfer(sqps_pkg::CMD_RESET, 24'h0, 0, 1'b0);
        transfer(sqps_pkg::CMD_RESET_EN, 24'h0, 0, 1'b0);
        transfer(sqps_pkg::CMD_FAST_READ, 24'h000010, 1, 1'b0);
        transfer(sqps_pkg::CMD_RESET, 24'h0, 0, 1'b0);
        transfer(sqps_pkg::CMD_EXIT_QUAD, 24'h0, 0, 1'b0);
        transfer(sqps_pkg::CMD_ENTER_QUAD, 24'h0, 0, 1'b0);
        transfer(sqps_pkg::CMD_RESET_EN, 24'h0, 0, 1'b0);
        transfer(sqps_pkg::CMD_RESET, 24'h0, 0, 1'b0);

        // plain mode set while a quad write is under way
        begin_access(sqps_pkg::CMD_QUAD_WRITE, 24'h000020, 1'b0);
        write_bytes(1);
        set_mode(1'b0);
        write_bytes(1);
        end_access();
        transfer(sqps_pkg::CMD_QUAD_WRITE, 24'h000030, 1, 1'b0);
        transfer(sqps_pkg::CMD_ENTER_QUAD, 24'h0, 0, 1'b0);
        transfer(sqps_pkg::CMD_READ, 24'h000020, 2, 1'b0);

        random_phase(0, 0, 1'b1);
        random_phase(84, 0, 1'b0);
        random_phase(0, 84, 1'b1);
        random_phase(26, 26, 1'b0);

        drain();
        repeat (16) @(posedge clk);
        if (sb.mismatches == 0 && sb.words_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
